// ===== hdl/trpt_pkg.sv =====
package trpt_pkg;

  localparam int MaxPointsDefault = 5;
  localparam int CoordW = 12;
  localparam int PointIdW = 3;

  typedef enum logic [1:0] {
    REQ_HEADER    = 2'd0,
    REQ_RECORD    = 2'd1,
    REQ_FRAME_END = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_type_t;

  typedef enum logic [1:0] {
    FLAG_DOWN    = 2'd0,
    FLAG_UP      = 2'd1,
    FLAG_CONTACT = 2'd2,
    FLAG_MARK    = 2'd3
  } flag_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RECORD = 2'd1,
    ST_SCAN   = 2'd2
  } state_t;

  // Command from the sequencer to the slot store, applied at the slot index; clr_seen clears every mark.
  typedef struct packed {
    logic              wr_pos;
    logic              set_active;
    logic              clr_active;
    logic              set_seen;
    logic              clr_seen;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } slot_cmd_t;

  // What the slot store reports about the slot at the current index, and whether any other slot is pending.
  typedef struct packed {
    logic              active;
    logic              seen;
    logic              pos_same;
    logic              others_pend;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } slot_stat_t;

  typedef struct packed {
    logic                valid;
    event_type_t         etype;
    logic [PointIdW-1:0] id;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic                last;
  } event_t;

endpackage

// ===== hdl/touch_report_point_tracker.sv =====
// Channel  Dir  Beat fields
// s_*      in   tuser: req_type; tdata: header_byte, x_high_byte, x_low_byte,
//               y_high_byte, y_low_byte
// m_*      out  tuser: event_type; tdata: contact_slot, x_pos, y_pos; tlast: last_of_run
//
// A header is taken in the idle state, a point record through the record state and a frame end
// by a walk over every slot, each stepped by the sequencer over the single slot-store port.
// A result stalled on the output holds the sequencer; s_tready is low meanwhile.
// The output register lets a finished result wait while the next beat comes in.
// rst is synchronous and clears all slots, marks and counts.
module touch_report_point_tracker #(
  parameter int MAX_POINTS = trpt_pkg::MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // header_byte, x_high_byte, x_low_byte, y_high_byte, y_low_byte
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // contact_slot, x_pos, y_pos, zero padding
  output logic [1:0]  m_tuser,   // event_type
  output logic        m_tlast    // last_of_run
);
  import trpt_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  slot_cmd_t           cmd;
  slot_stat_t          stat;
  logic [IW-1:0]       idx;
  event_t              ev;
  logic                out_free;
  event_type_t         out_type;
  logic [PointIdW-1:0] out_id;
  logic [CoordW-1:0]   out_x;
  logic [CoordW-1:0]   out_y;
  logic                out_last;

  assign out_free = !m_tvalid || m_tready;

  trpt_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req_type    (s_tuser),
    .header_byte (s_tdata[7:0]),
    .x_high_byte (s_tdata[15:8]),
    .x_low_byte  (s_tdata[23:16]),
    .y_high_byte (s_tdata[31:24]),
    .y_low_byte  (s_tdata[39:32]),
    .stat        (stat),
    .cmd         (cmd),
    .idx         (idx),
    .out_free    (out_free),
    .ev          (ev)
  );

  trpt_slots #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW)
  ) u_slots (
    .clk  (clk),
    .rst  (rst),
    .idx  (idx),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ev.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid) begin
      out_type <= ev.etype;
      out_id   <= ev.id;
      out_x    <= ev.x;
      out_y    <= ev.y;
      out_last <= ev.last;
    end
  end

  assign m_tdata = {5'b0, out_y, out_x, out_id};
  assign m_tuser = out_type;
  assign m_tlast = out_last;

endmodule

// ===== hdl/trpt_slots.sv =====
module trpt_slots #(
  parameter int MAX_POINTS = trpt_pkg::MaxPointsDefault,
  parameter int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IW-1:0]         idx,
  input  trpt_pkg::slot_cmd_t   cmd,
  output trpt_pkg::slot_stat_t  stat
);
  import trpt_pkg::*;

  logic [MAX_POINTS-1:0] active;
  logic [MAX_POINTS-1:0] seen;
  logic [CoordW-1:0]     slot_x [MAX_POINTS];
  logic [CoordW-1:0]     slot_y [MAX_POINTS];
  logic [MAX_POINTS-1:0] pend;
  logic [MAX_POINTS-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      seen   <= '0;
    end else begin
      if (cmd.set_active) begin
        active[idx] <= 1'b1;
      end else if (cmd.clr_active) begin
        active[idx] <= 1'b0;
      end
      if (cmd.clr_seen) begin
        seen <= '0;
      end else if (cmd.set_seen) begin
        seen[idx] <= 1'b1;
      end
    end
  end

  // Positions are only ever read for active slots, which always hold a written value.
  always_ff @(posedge clk) begin
    if (cmd.wr_pos) begin
      slot_x[idx] <= cmd.x;
      slot_y[idx] <= cmd.y;
    end
  end

  assign pend = active & ~seen;
  assign sel  = MAX_POINTS'(1) << idx;

  always_comb begin
    stat.active      = active[idx];
    stat.seen        = seen[idx];
    stat.x           = slot_x[idx];
    stat.y           = slot_y[idx];
    stat.pos_same    = (slot_x[idx] == cmd.x) && (slot_y[idx] == cmd.y);
    stat.others_pend = |(pend & ~sel);
  end

endmodule

// ===== hdl/trpt_ctrl.sv =====
module trpt_ctrl #(
  parameter int MAX_POINTS = trpt_pkg::MaxPointsDefault,
  parameter int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [7:0]            header_byte,
  input  logic [7:0]            x_high_byte,
  input  logic [7:0]            x_low_byte,
  input  logic [7:0]            y_high_byte,
  input  logic [7:0]            y_low_byte,
  input  trpt_pkg::slot_stat_t  stat,
  output trpt_pkg::slot_cmd_t   cmd,
  output logic [IW-1:0]         idx,
  input  logic                  out_free,
  output trpt_pkg::event_t      ev
);
  import trpt_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [3:0] MaxId = 4'(MAX_POINTS);
  localparam logic [IW-1:0] LastSlot = IW'(MAX_POINTS - 1);

  state_t            state, state_next;
  logic [CW-1:0]     rep_cnt, rep_cnt_next;
  logic [CW-1:0]     rec_idx, rec_idx_next;
  logic [IW-1:0]     scan_idx, scan_idx_next;
  flag_t             rec_flag, rec_flag_next;
  logic [3:0]        rec_id, rec_id_next;
  logic [CoordW-1:0] rec_x, rec_x_next;
  logic [CoordW-1:0] rec_y, rec_y_next;

  logic       id_ok;
  logic       emit;
  logic [3:0] hdr_cnt;

  assign id_ok   = rec_id < MaxId;
  assign hdr_cnt = header_byte[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_cnt  <= '0;
      rec_idx  <= '0;
      scan_idx <= '0;
    end else begin
      rep_cnt  <= rep_cnt_next;
      rec_idx  <= rec_idx_next;
      scan_idx <= scan_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    rec_flag <= rec_flag_next;
    rec_id   <= rec_id_next;
    rec_x    <= rec_x_next;
    rec_y    <= rec_y_next;
  end

  always_comb begin
    state_next    = state;
    rep_cnt_next  = rep_cnt;
    rec_idx_next  = rec_idx;
    scan_idx_next = scan_idx;
    rec_flag_next = rec_flag;
    rec_id_next   = rec_id;
    rec_x_next    = rec_x;
    rec_y_next    = rec_y;
    in_ready      = 1'b0;
    emit          = 1'b0;

    cmd            = '0;
    cmd.x          = rec_x;
    cmd.y          = rec_y;
    idx            = id_ok ? rec_id[IW-1:0] : '0;

    ev       = '0;
    ev.etype = EV_DOWN;
    ev.id    = PointIdW'(idx);
    ev.x     = rec_x;
    ev.y     = rec_y;
    ev.last  = 1'b1;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (req_type)
            REQ_HEADER: begin
              rep_cnt_next = (hdr_cnt > MaxId) ? CW'(MAX_POINTS) : CW'(hdr_cnt);
              rec_idx_next = '0;
              cmd.clr_seen = 1'b1;
            end
            REQ_RECORD: begin
              rec_flag_next = flag_t'(x_high_byte[7:6]);
              rec_x_next    = {x_high_byte[3:0], x_low_byte};
              rec_id_next   = y_high_byte[7:4];
              rec_y_next    = {y_high_byte[3:0], y_low_byte};
              state_next    = ST_RECORD;
            end
            REQ_FRAME_END: begin
              scan_idx_next = '0;
              state_next    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RECORD: begin
        if (rec_idx >= rep_cnt) begin
          state_next = ST_IDLE;
        end else if (!id_ok) begin
          rec_idx_next = CW'(rec_idx + 1'b1);
          state_next   = ST_IDLE;
        end else begin
          unique case (rec_flag)
            FLAG_DOWN: begin
              emit           = 1'b1;
              ev.etype       = EV_DOWN;
              cmd.set_active = 1'b1;
            end
            FLAG_CONTACT: begin
              if (!stat.active) begin
                emit           = 1'b1;
                ev.etype       = EV_DOWN;
                cmd.set_active = 1'b1;
              end else if (!stat.pos_same) begin
                emit     = 1'b1;
                ev.etype = EV_MOVE;
              end
            end
            FLAG_UP: begin
              emit           = 1'b1;
              ev.etype       = EV_UP;
              cmd.clr_active = 1'b1;
            end
            default: begin
            end
          endcase
          // Nothing is committed until the result has somewhere to go.
          if (!emit || out_free) begin
            cmd.wr_pos   = emit;
            cmd.set_seen = 1'b1;
            ev.valid     = emit;
            rec_idx_next = CW'(rec_idx + 1'b1);
            state_next   = ST_IDLE;
          end else begin
            cmd.set_active = 1'b0;
            cmd.clr_active = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        idx      = scan_idx;
        ev.id    = PointIdW'(scan_idx);
        ev.etype = EV_UP;
        ev.x     = stat.x;
        ev.y     = stat.y;
        ev.last  = !stat.others_pend;
        if (stat.active && !stat.seen) begin
          if (out_free) begin
            ev.valid       = 1'b1;
            cmd.clr_active = 1'b1;
          end
        end
        if (!(stat.active && !stat.seen) || out_free) begin
          if (scan_idx == LastSlot) begin
            rep_cnt_next = '0;
            rec_idx_next = '0;
            state_next   = ST_IDLE;
          end else begin
            scan_idx_next = IW'(scan_idx + 1'b1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_ev_has_room: assert property (@(posedge clk) disable iff (rst)
    ev.valid |-> out_free)
    else $error("event issued while the output register is full");

  a_idx_bounded: assert property (@(posedge clk) disable iff (rst)
    rec_idx <= rep_cnt)
    else $error("record index ran past the reported count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_idx <= LastSlot)
    else $error("slot walk left the slot range");

  a_scan_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && state_next == ST_IDLE) |=> (rep_cnt == '0 && rec_idx == '0))
    else $error("frame end did not clear the record count");

endmodule
